/* sv/slfc_pkg.sv */
// slfc_pkg: shared constants and types for the serial link frame controller
// no dependencies
`default_nettype none
package slfc_pkg;
  localparam logic [2:0] OP_RX   = 3'd0;
  localparam logic [2:0] OP_TICK = 3'd1;
  localparam logic [2:0] OP_KEY  = 3'd2;
  localparam logic [2:0] OP_ID   = 3'd3;
  localparam logic [2:0] OP_TX   = 3'd4;

  localparam logic [2:0] K_STATUS = 3'd0;
  localparam logic [2:0] K_ACK    = 3'd1;
  localparam logic [2:0] K_ID     = 3'd2;
  localparam logic [2:0] K_TX     = 3'd3;
  localparam logic [2:0] K_LOST   = 3'd4;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ONE   = 3'd1;
  localparam logic [2:0] PH_BIN   = 3'd2;
  localparam logic [2:0] PH_R     = 3'd3;
  localparam logic [2:0] PH_TEXT  = 3'd4;

  localparam logic [7:0] HDR_STATUS = 8'h03;
  localparam logic [7:0] HDR_ACK    = 8'h06;
  localparam logic [7:0] HDR_SECOND = 8'h01;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] STATUS_MASK = 8'h13;
  localparam logic [7:0] KEY_ID     = 8'h02;
  localparam int unsigned STORE_DEPTH = 21;
  localparam int unsigned ADDR_W = 5;

  typedef struct packed {
    logic [2:0]  kind;
    logic        power_on;
    logic        paused;
    logic        fault;
    logic [4:0]  masked_status;
    logic [7:0]  program_res;
    logic [13:0] running_time;
    logic [7:0]  alarm_count;
    logic        state_changed;
    logic [7:0]  out_byte;
    logic        link_alarm;
    logic        last;
  } result_t;

  // memory port request between sequencer and frame store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

/* sv/slfc_store.sv */
// slfc_store: 21-byte frame store, one write and one registered read port
// depends on slfc_pkg
`default_nettype none
module slfc_store (
  input  wire logic              clk,
  input  wire slfc_pkg::mem_req_t req,
  output logic [7:0]             rdata
);
  logic [7:0] mem [slfc_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

/* sv/slfc_core.sv */
// slfc_core: sequencer that parses bytes, walks the frame store and emits results
// depends on slfc_pkg and slfc_store
`default_nettype none
module slfc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        lost_limit,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        operation,
  input  wire logic [7:0]        data_byte,
  input  wire logic [7:0]        key_value,
  input  wire logic              net_connected,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output slfc_pkg::result_t      out_res
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUM   = 7'b0000010,  // walk bytes 0..8 of a binary frame
    S_DEC   = 7'b0000100,  // read the status fields
    S_IDCHK = 7'b0001000,  // check the two closing '@'
    S_IDOUT = 7'b0010000,  // stream 17 id bytes
    S_TXOUT = 7'b0100000,  // stream 5 reply bytes
    S_WAIT  = 7'b1000000   // never entered by the sequencer
  } state_t;

  state_t state;
  logic [2:0] parse_phase;
  logic [4:0] byte_index;
  logic [4:0] previous_status;
  logic [7:0] lost_ticks;
  logic alarm_bit, id_read_mode, send_pending, key_pending;
  logic [7:0] held_key;

  slfc_pkg::mem_req_t req;
  logic [7:0] rdata;
  logic [4:0] cnt;        // issued read address / emitted count
  logic       rd_live;    // rdata holds the read issued last cycle
  logic [4:0] rd_addr;
  logic [7:0] sum;
  logic [7:0] hdr, st, prog, tb0;
  logic       at_ok;
  logic [7:0] tx_b [5];

  slfc_store u_store (.clk(clk), .req(req), .rdata(rdata));

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic acc;
  assign acc = in_valid && in_ready;

  // write path is combinational from the accepted rx byte
  always_comb begin
    req = '0;
    req.raddr = cnt;
    if (acc && operation == slfc_pkg::OP_RX) begin
      if (data_byte == slfc_pkg::CH_DOLLAR && id_read_mode) begin
        req.we = 1'b1; req.waddr = 5'd0;
      end else begin
        unique case (parse_phase)
          slfc_pkg::PH_HUNT: begin
            req.we = data_byte == slfc_pkg::HDR_STATUS || data_byte == slfc_pkg::HDR_ACK;
            req.waddr = 5'd0;
          end
          slfc_pkg::PH_ONE: begin
            req.we = data_byte == slfc_pkg::HDR_SECOND; req.waddr = 5'd1;
          end
          slfc_pkg::PH_BIN: begin
            req.we = byte_index < 5'd7; req.waddr = byte_index + 5'd2;
          end
          slfc_pkg::PH_R: begin
            req.we = data_byte == slfc_pkg::CH_R; req.waddr = 5'd1;
          end
          slfc_pkg::PH_TEXT: begin
            req.we = byte_index < 5'd19; req.waddr = byte_index + 5'd2;
          end
          default: req.we = 1'b0;
        endcase
      end
    end
    req.wdata = data_byte;
  end

  logic [7:0] lt_inc;
  assign lt_inc = lost_ticks + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0;
      previous_status <= '0; lost_ticks <= '0; alarm_bit <= 1'b0;
      id_read_mode <= 1'b0; send_pending <= 1'b0; key_pending <= 1'b0;
      held_key <= '0; out_valid <= 1'b0; cnt <= '0; rd_live <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      rd_live <= 1'b0;
      unique case (state)
        S_IDLE: if (acc) begin
          case (operation)
            slfc_pkg::OP_RX: begin
              if (data_byte == slfc_pkg::CH_DOLLAR && id_read_mode) begin
                parse_phase <= slfc_pkg::PH_R; byte_index <= '0;
              end else begin
                unique case (parse_phase)
                  slfc_pkg::PH_HUNT:
                    if (data_byte == slfc_pkg::HDR_STATUS || data_byte == slfc_pkg::HDR_ACK)
                      parse_phase <= slfc_pkg::PH_ONE;
                    else byte_index <= '0;
                  slfc_pkg::PH_ONE:
                    if (data_byte == slfc_pkg::HDR_SECOND) parse_phase <= slfc_pkg::PH_BIN;
                    else begin parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0; end
                  slfc_pkg::PH_BIN:
                    if (byte_index < 5'd7) byte_index <= byte_index + 5'd1;
                    else begin
                      parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0;
                      cnt <= '0; sum <= '0; state <= S_SUM; rd_live <= 1'b0;
                    end
                  slfc_pkg::PH_R:
                    if (data_byte == slfc_pkg::CH_R) begin
                      parse_phase <= slfc_pkg::PH_TEXT; byte_index <= '0;
                    end else begin parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0; end
                  slfc_pkg::PH_TEXT:
                    if (byte_index >= 5'd18) begin
                      parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0;
                      cnt <= 5'd19; at_ok <= 1'b1; state <= S_IDCHK;
                    end else byte_index <= byte_index + 5'd1;
                  default: begin parse_phase <= slfc_pkg::PH_HUNT; byte_index <= '0; end
                endcase
              end
            end
            slfc_pkg::OP_TICK: if (net_connected) begin
              if (lt_inc == lost_limit) begin
                lost_ticks <= '0; key_pending <= 1'b1; send_pending <= 1'b1;
                held_key <= '0; alarm_bit <= 1'b1;
                out_res <= '0; out_res.kind <= slfc_pkg::K_LOST;
                out_res.link_alarm <= 1'b1; out_res.last <= 1'b1; out_valid <= 1'b1;
              end else lost_ticks <= lt_inc;
            end
            slfc_pkg::OP_KEY: begin
              key_pending <= 1'b1; send_pending <= 1'b1; held_key <= key_value;
            end
            slfc_pkg::OP_ID: begin
              id_read_mode <= 1'b1; key_pending <= 1'b1; send_pending <= 1'b1;
              held_key <= slfc_pkg::KEY_ID;
            end
            slfc_pkg::OP_TX: if (send_pending) begin
              send_pending <= 1'b0; key_pending <= 1'b0;
              tx_b[0] <= key_pending ? slfc_pkg::HDR_ACK : slfc_pkg::HDR_STATUS;
              tx_b[1] <= slfc_pkg::HDR_SECOND; tx_b[2] <= '0;
              tx_b[3] <= key_pending ? held_key : 8'd0;
              tx_b[4] <= (key_pending ? slfc_pkg::HDR_ACK : slfc_pkg::HDR_STATUS)
                         + slfc_pkg::HDR_SECOND + (key_pending ? held_key : 8'd0);
              cnt <= '0; state <= S_TXOUT;
            end
            default: ;
          endcase
        end
        S_SUM: begin
          // address cnt issued this cycle, data of cnt-1 arrives
          if (rd_live) begin
            if (rd_addr == 5'd8) begin
              if (sum == rdata) begin
                lost_ticks <= '0; alarm_bit <= 1'b0; send_pending <= 1'b1;
                if (hdr == slfc_pkg::HDR_STATUS) begin
                  cnt <= 5'd4; state <= S_DEC;
                end else begin
                  key_pending <= 1'b0;
                  out_res <= '0; out_res.kind <= slfc_pkg::K_ACK; out_res.last <= 1'b1;
                  out_valid <= 1'b1; state <= S_IDLE;
                end
              end else state <= S_IDLE;
            end else begin
              sum <= sum + rdata;
              if (rd_addr == 5'd0) hdr <= rdata;
              if (rd_addr == 5'd2) st <= rdata;
            end
          end
          if (cnt <= 5'd8) begin
            rd_live <= 1'b1; rd_addr <= cnt; cnt <= cnt + 5'd1;
          end
        end
        S_DEC: begin
          // reads 4..7 give program, time bytes, alarm count
          if (rd_live) begin
            unique case (rd_addr)
              5'd4: prog <= rdata;
              5'd5: tb0 <= rdata;
              5'd6: out_res.running_time <= 14'(tb0) * 14'd60 + 14'(rdata);
              default: begin
                out_res.kind <= slfc_pkg::K_STATUS;
                out_res.power_on <= st[0]; out_res.paused <= st[1];
                out_res.fault <= st[4];
                out_res.masked_status <= st[4:0] & slfc_pkg::STATUS_MASK[4:0];
                out_res.program_res <= prog; out_res.alarm_count <= rdata;
                out_res.state_changed <=
                  (st[4:0] & slfc_pkg::STATUS_MASK[4:0]) != previous_status;
                previous_status <= st[4:0] & slfc_pkg::STATUS_MASK[4:0];
                out_res.out_byte <= '0; out_res.link_alarm <= 1'b0;
                out_res.last <= 1'b1; out_valid <= 1'b1; state <= S_IDLE;
              end
            endcase
          end
          if (cnt <= 5'd7) begin
            rd_live <= 1'b1; rd_addr <= cnt; cnt <= cnt + 5'd1;
          end
        end
        S_IDCHK: begin
          if (rd_live) begin
            if (rdata != slfc_pkg::CH_AT) at_ok <= 1'b0;
            if (rd_addr == 5'd20) begin
              if (at_ok && rdata == slfc_pkg::CH_AT) begin
                id_read_mode <= 1'b0; cnt <= 5'd2; state <= S_IDOUT;
              end else state <= S_IDLE;
            end
          end
          if (cnt <= 5'd20 && cnt >= 5'd19) begin
            rd_live <= 1'b1; rd_addr <= cnt; cnt <= cnt + 5'd1;
          end
        end
        S_IDOUT: begin
          // one read in flight, pushed into the output register when it is free
          if (!rd_live && (!out_valid || out_ready)) begin
            rd_live <= 1'b1; rd_addr <= cnt;
          end
          if (rd_live) begin
            out_res <= '0; out_res.kind <= slfc_pkg::K_ID; out_res.out_byte <= rdata;
            out_res.link_alarm <= alarm_bit; out_res.last <= rd_addr == 5'd18;
            out_valid <= 1'b1; cnt <= cnt + 5'd1;
            if (rd_addr == 5'd18) state <= S_IDLE;
          end
        end
        S_TXOUT: if (!out_valid || out_ready) begin
          out_res <= '0; out_res.kind <= slfc_pkg::K_TX;
          out_res.out_byte <= tx_b[cnt[2:0]]; out_res.link_alarm <= alarm_bit;
          out_res.last <= cnt == 5'd4; out_valid <= 1'b1; cnt <= cnt + 5'd1;
          if (cnt == 5'd4) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_id_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDOUT && rd_live) |-> (rd_addr >= 5'd2 && rd_addr <= 5'd18))
    else $error("id read out of range");

  a_alarm_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == slfc_pkg::K_LOST) |-> alarm_bit)
    else $error("link lost without alarm");
endmodule
`default_nettype wire

/* sv/serial_link_frame_controller.sv */
// serial_link_frame_controller: top level with stream ports and config register
// depends on slfc_pkg and slfc_core
//
// usage: one transfer on s_axis carries one item (rx byte, tick, key request,
// id-read request or transmit poll); results leave on m_axis, tlast on the final
// result of each run, tuser holding the kind code.
// timing: a binary frame's closing byte starts the checksum walk over the
// frame store (one byte read per cycle from its synchronous port) and a status
// frame then reads its fields; id frames give 17 results with one store read
// in flight at a time, reply frames 5 results at one per cycle while
// m_axis_tready stays high.
// throughput: one item at a time; the next item is taken once the previous one
// has finished and its last result has left the output register.
// reset: rst clears parser, counters, pending flags and sets lost_limit to 5.
// the frame store is not cleared; only written entries are ever read.
// stall: a held m_axis_tready freezes result emission; s_axis_tready stays low.
`default_nettype none
module serial_link_frame_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] operation, [10:3] data_byte, [18:11] key_value, [19] net_connected
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] power_on, [1] paused, [2] fault, [7:3] masked_status, [15:8] program_res,
  // [29:16] running_time, [37:30] alarm_count, [38] state_changed,
  // [46:39] out_byte, [47] link_alarm
  output logic [47:0]      m_axis_tdata,
  // [2:0] kind
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  logic [7:0] lost_limit;
  slfc_pkg::result_t res;

  // lost limit register
  always_ff @(posedge clk) begin
    if (rst) lost_limit <= 8'd5;
    else if (cfg_we) lost_limit <= cfg_wdata;
  end

  slfc_core u_core (
    .clk(clk), .rst(rst), .lost_limit(lost_limit),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .operation(s_axis_tdata[2:0]), .data_byte(s_axis_tdata[10:3]),
    .key_value(s_axis_tdata[18:11]), .net_connected(s_axis_tdata[19]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {res.link_alarm, res.out_byte, res.state_changed, res.alarm_count,
                         res.running_time, res.program_res, res.masked_status, res.fault,
                         res.paused, res.power_on};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

/* bench/slfc_checker.sv */
`timescale 1ns / 1ps
// slfc_checker: watches the stream and config ports of the frame controller,
// predicts every result and compares it field by field
// depends on slfc_pkg
module slfc_checker
  import slfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               errors,
  output int               outstanding
);
  // own copy of the block state
  logic [7:0] lost_limit;
  logic [2:0] phase;
  logic [4:0] idx;
  logic [7:0] store [STORE_DEPTH];
  logic [4:0] prev_status;
  logic [7:0] lost_cnt;
  logic       alarm;
  logic       id_mode;
  logic       tx_due;
  logic       key_due;
  logic [7:0] key_held;
  result_t    results_due [$];
  int         err_cnt;

  function automatic result_t plain_result(logic [2:0] kind, logic [7:0] b, logic lst);
    result_t r;
    r = '0;
    r.kind = kind;
    r.out_byte = b;
    r.link_alarm = alarm;
    r.last = lst;
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int done;
    logic [7:0] sum;
    logic [7:0] st;
    result_t r;
    done = 0;
    if (b == CH_DOLLAR && id_mode) begin
      store[0] = b;
      phase = PH_R;
      idx = 0;
      return;
    end
    case (phase)
      PH_HUNT: begin
        if (b == HDR_STATUS || b == HDR_ACK) begin
          store[0] = b;
          phase = PH_ONE;
        end else begin
          phase = PH_HUNT;
          idx = 0;
        end
      end
      PH_ONE: begin
        if (b == HDR_SECOND) begin
          store[1] = b;
          phase = PH_BIN;
        end else begin
          phase = PH_HUNT;
          idx = 0;
        end
      end
      PH_BIN: begin
        if (idx < 7) begin
          idx = idx + 1;
          store[(idx + 1) & 15] = b;
        end else begin
          sum = 0;
          for (int n = 0; n < 8; n++) sum = sum + store[n];
          if (sum == store[8]) done = 1;
          phase = PH_HUNT;
          idx = 0;
        end
      end
      PH_R: begin
        if (b == CH_R) begin
          store[1] = b;
          phase = PH_TEXT;
          idx = 0;
        end else begin
          phase = PH_HUNT;
          idx = 0;
        end
      end
      PH_TEXT: begin
        if (idx < 19) begin
          store[idx + 2] = b;
          idx = idx + 1;
        end
        if (idx >= 19) begin
          if (store[19] == CH_AT && store[20] == CH_AT) done = 2;
          phase = PH_HUNT;
          idx = 0;
        end
      end
      default: begin
        phase = PH_HUNT;
        idx = 0;
      end
    endcase

    if (done == 1) begin
      lost_cnt = 0;
      alarm = 0;
      tx_due = 1;
      if (store[0] == HDR_STATUS) begin
        st = store[2];
        r = plain_result(K_STATUS, 8'h00, 1'b1);
        r.power_on = st[0];
        r.paused = st[1];
        r.fault = st[4];
        r.masked_status = st[4:0] & STATUS_MASK[4:0];
        r.program_res = store[4];
        r.running_time = 14'(store[5] * 60 + store[6]);
        r.alarm_count = store[7];
        r.state_changed = (r.masked_status != prev_status);
        prev_status = r.masked_status;
        results_due.push_back(r);
      end else begin
        key_due = 0;
        results_due.push_back(plain_result(K_ACK, 8'h00, 1'b1));
      end
    end else if (done == 2) begin
      id_mode = 0;
      for (int n = 0; n < 17; n++)
        results_due.push_back(plain_result(K_ID, store[n + 2], n == 16));
    end
  endtask

  task automatic predict_item(input logic [23:0] d);
    logic [7:0] frame [5];
    logic [7:0] sum;
    case (d[2:0])
      OP_RX: take_byte(d[10:3]);
      OP_TICK: begin
        if (d[19]) begin
          lost_cnt = lost_cnt + 1;
          if (lost_cnt == lost_limit) begin
            lost_cnt = 0;
            key_due = 1;
            tx_due = 1;
            key_held = 8'h00;
            alarm = 1;
            results_due.push_back(plain_result(K_LOST, 8'h00, 1'b1));
          end
        end
      end
      OP_KEY: begin
        key_due = 1;
        tx_due = 1;
        key_held = d[18:11];
      end
      OP_ID: begin
        id_mode = 1;
        key_due = 1;
        tx_due = 1;
        key_held = KEY_ID;
      end
      OP_TX: begin
        if (tx_due) begin
          tx_due = 0;
          frame[0] = HDR_STATUS;
          frame[1] = HDR_SECOND;
          frame[2] = 8'h00;
          frame[3] = 8'h00;
          if (key_due) begin
            frame[0] = HDR_ACK;
            frame[3] = key_held;
            key_due = 0;
          end
          sum = frame[0] + frame[1] + frame[2] + frame[3];
          frame[4] = sum;
          for (int n = 0; n < 5; n++)
            results_due.push_back(plain_result(K_TX, frame[n], n == 4));
        end
      end
      default: ;  // unused operation codes are ignored
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      lost_limit = 8'd5;
      phase = PH_HUNT;
      idx = 0;
      prev_status = 0;
      lost_cnt = 0;
      alarm = 0;
      id_mode = 0;
      tx_due = 0;
      key_due = 0;
      key_held = 0;
      results_due.delete();
      err_cnt = 0;
    end else begin
      if (cfg_we) lost_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.power_on = m_axis_tdata[0];
        got.paused = m_axis_tdata[1];
        got.fault = m_axis_tdata[2];
        got.masked_status = m_axis_tdata[7:3];
        got.program_res = m_axis_tdata[15:8];
        got.running_time = m_axis_tdata[29:16];
        got.alarm_count = m_axis_tdata[37:30];
        got.state_changed = m_axis_tdata[38];
        got.out_byte = m_axis_tdata[46:39];
        got.link_alarm = m_axis_tdata[47];
        got.last = m_axis_tlast;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("power_on", want.power_on, got.power_on);
          check_field("paused", want.paused, got.paused);
          check_field("fault", want.fault, got.fault);
          check_field("masked_status", want.masked_status, got.masked_status);
          check_field("program_res", want.program_res, got.program_res);
          check_field("running_time", want.running_time, got.running_time);
          check_field("alarm_count", want.alarm_count, got.alarm_count);
          check_field("state_changed", want.state_changed, got.state_changed);
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("link_alarm", want.link_alarm, got.link_alarm);
          check_field("last", want.last, got.last);
        end
      end
    end
    errors <= err_cnt;
    outstanding <= results_due.size();
  end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for serial_link_frame_controller
// depends on slfc_pkg, slfc_checker and the block itself
module tb_top;
  import slfc_pkg::*;

  // operation codes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 60;   // covers the slowest frame close
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          errors;
  int          outstanding;

  int  items_sent = 0;
  int  cycles = 0;
  bit  quiet = 0;       // no idling on either side in the closing stretch
  bit  hold_req = 0;    // asks the receiver for one long hold-off

  always #2 clk = ~clk;

  serial_link_frame_controller uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  slfc_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .errors(errors), .outstanding(outstanding)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && !rst && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one transfer on the input side, then maybe an idle burst
  task automatic send_item(input logic [2:0] op, input logic [7:0] b,
                           input logic [7:0] key, input logic conn);
    s_axis_tdata <= {4'b0000, conn, key, b, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic rx(input logic [7:0] b);
    send_item(OP_RX, b, 8'($urandom), 1'($urandom));
  endtask

  // binary frame: header, 0x01, six data bytes, sum byte, closing byte
  task automatic binary_frame(input logic [7:0] hdr, input bit corrupt,
                              input logic [7:0] st);
    logic [7:0] body [6];
    logic [7:0] sum;
    body[0] = st;
    for (int n = 1; n < 6; n++) body[n] = 8'($urandom);
    sum = hdr + HDR_SECOND;
    rx(hdr);
    rx(HDR_SECOND);
    for (int n = 0; n < 6; n++) begin
      sum = sum + body[n];
      rx(body[n]);
    end
    rx(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
    rx(8'($urandom));
  endtask

  // text frame after an id-read request: '$', 'R', 17 id bytes, two '@'
  task automatic text_frame(input bit bad_tail);
    logic [7:0] b;
    send_item(OP_ID, 8'($urandom), 8'($urandom), 1'($urandom));
    rx(CH_DOLLAR);
    rx(CH_R);
    for (int n = 0; n < 17; n++) begin
      b = 8'($urandom);
      if (b == CH_DOLLAR && $urandom_range(0, 3) != 0) b = 8'h25;
      rx(b);
    end
    rx(CH_AT);
    rx(bad_tail ? 8'h41 : CH_AT);
  endtask

  // pause the sender until every expected result is in, then let the block settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_lost_limit(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      binary_frame($urandom_range(0, 1) ? HDR_STATUS : HDR_ACK,
                   $urandom_range(0, 4) == 0, 8'($urandom));
    else if (pick < 42)
      text_frame($urandom_range(0, 5) == 0);
    else if (pick < 60)
      send_item(OP_TICK, 8'($urandom), 8'($urandom), $urandom_range(0, 4) != 0);
    else if (pick < 72)
      send_item(OP_TX, 8'($urandom), 8'($urandom), 1'($urandom));
    else if (pick < 78)
      send_item(OP_KEY, 8'($urandom), 8'($urandom), 1'($urandom));
    else if (pick < 80)
      send_item(OP_ID, 8'($urandom), 8'($urandom), 1'($urandom));
    else if (pick < 84)
      send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                8'($urandom), 1'($urandom));
    else if (pick < 90)
      // broken frame start: header then junk
      begin rx($urandom_range(0, 1) ? HDR_STATUS : HDR_ACK); rx(8'($urandom)); end
    else
      rx(8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, frame corner cases
    repeat (5) send_item(OP_TICK, 8'h00, 8'h00, 1'b1);       // default limit alarms
    send_item(OP_TICK, 8'hff, 8'hff, 1'b0);                  // disconnected tick
    send_item(OP_TX, 8'h00, 8'h00, 1'b0);                    // reply with key zero
    send_item(OP_TX, 8'h00, 8'h00, 1'b0);                    // nothing pending
    binary_frame(HDR_STATUS, 0, 8'hff);
    binary_frame(HDR_STATUS, 0, 8'h00);
    binary_frame(HDR_STATUS, 1, 8'h13);                      // bad sum byte
    send_item(OP_KEY, 8'h00, 8'hff, 1'b1);
    binary_frame(HDR_ACK, 0, 8'h5a);                         // ack drops the key
    send_item(OP_TX, 8'hff, 8'h00, 1'b1);
    rx(CH_DOLLAR);                                           // '$' outside id mode
    send_item(OP_SPARE_LO, 8'hff, 8'hff, 1'b1);
    send_item(OP_SPARE_HI, 8'hff, 8'hff, 1'b1);
    text_frame(0);
    text_frame(1);
    // '$' in id mode cuts a binary frame short
    send_item(OP_ID, 8'h00, 8'h00, 1'b0);
    rx(HDR_STATUS);
    rx(HDR_SECOND);
    rx(8'h11);
    text_frame(0);

    // long receiver hold-off while results keep coming
    drain();
    hold_req = 1;
    for (int n = 0; n < 6; n++) begin
      send_item(OP_KEY, 8'h00, 8'($urandom), 1'b0);
      send_item(OP_TX, 8'h00, 8'h00, 1'b0);
    end
    text_frame(0);

    // random phases across several lost limits, extremes included
    set_lost_limit(8'd1);
    while (items_sent < 230) random_item();
    set_lost_limit(8'd255);
    while (items_sent < 300) random_item();
    set_lost_limit(8'($urandom_range(2, 12)));
    while (items_sent < 380) random_item();
    set_lost_limit(8'd3);
    quiet = 1;
    while (items_sent < 460) random_item();

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
